[hw/rtl/vfir_pkg.sv]
// Package for the vertical FIR line buffer: payload structs, register map,
// default parameters. No dependencies.
package vfir_pkg;
  localparam int DefMaxWidth  = 4096;
  localparam int DefPixelBits = 16;
  localparam int DefTaps      = 5;
  localparam int NumLines     = 4;
  localparam int CoefW        = 11;
  localparam int RecipW       = 24;
  localparam int BiasW        = 32;
  localparam int SumW         = 31;  // 5 * 2^10 * 2^16 fits signed 31
  localparam int ProdW        = 55;

  typedef enum logic [2:0] {
    REG_COEF0 = 3'd0, REG_COEF1 = 3'd1, REG_COEF2 = 3'd2, REG_COEF3 = 3'd3,
    REG_COEF4 = 3'd4, REG_RECIP = 3'd5, REG_BIAS = 3'd6, REG_MAX = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        row_end;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        run_last;
    logic        frame_done;
  } out_item_t;

  // One filter job handed from the line buffer stage to the arithmetic stages.
  typedef struct packed {
    logic [4:0][15:0] tap;       // tap[0] is two rows above center
    logic             run_last;
    logic             frame_done;
  } job_t;

  typedef struct packed {
    logic signed [4:0][CoefW-1:0] coef;
    logic signed [RecipW-1:0]     recip;
    logic signed [BiasW-1:0]      bias;
    logic [15:0]                  max_value;
  } cfg_t;
endpackage

[hw/rtl/vfir_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[hw/rtl/vfir_front.sv]
// Line buffer front end: column/row tracking, four line RAMs, emits up to
// three filter jobs per pixel. Depends on vfir_pkg and vfir_ram.
module vfir_front #(
  parameter int MAX_WIDTH  = vfir_pkg::DefMaxWidth,
  parameter int PIXEL_BITS = vfir_pkg::DefPixelBits
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vfir_pkg::in_item_t in_item,
  output logic              job_valid,
  input  logic              job_ready,
  output vfir_pkg::job_t    job
);
  import vfir_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [AW-1:0] column_count;
  logic [2:0]    rows_seen;

  // stage A: RAM read issued; stage B: column + pixel available
  logic          b_valid;
  logic [15:0]   b_pix;
  logic          b_end, b_last;
  logic [AW-1:0] b_col;
  logic [2:0]    b_rows;
  logic [NumLines-1:0][15:0] rd;

  // emission state for stage B (one or several jobs)
  logic [1:0] b_j;       // current center offset j being emitted
  logic       b_first;   // first cycle at stage B
  logic       b_done_now;
  logic       b_adv;

  logic [2:0]    rows_clamped;
  logic [1:0]    j_start;
  logic [1:0]    j_cur;
  logic [4:0][15:0] v;
  logic          emit;

  logic take;
  assign in_ready = !b_valid || b_adv;
  assign take     = in_valid && in_ready;

  // line write happens when stage B retires, same column chain shift
  logic wr;
  assign wr = b_valid && b_adv;

  // forward write data to a same-column read by the next item (rows of
  // width one, or a column wrap)
  logic          fwd;
  logic [NumLines-1:0][15:0] rd_fwd;
  logic [NumLines-1:0][15:0] rd_eff;
  assign rd_eff = fwd ? rd_fwd : rd;

  for (genvar g = 0; g < NumLines; g++) begin : g_line
    logic [15:0] wdata;
    if (g == 0) begin : g_w0
      assign wdata = b_pix;
    end else begin : g_wn
      assign wdata = rd_eff[g-1];
    end
    vfir_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_ram (
      .clk(clk), .we(wr), .waddr(b_col), .wdata(wdata),
      .re(take), .raddr(column_count), .rdata(rd[g])
    );
  end

  always_comb begin
    rows_clamped = b_rows;
    j_start = (b_rows < 3'd2) ? b_rows[1:0] : 2'd2;
    j_cur   = b_first ? j_start : b_j;
    v[0] = b_pix;
    for (int s = 1; s <= 4; s++) v[s] = rd_eff[s-1];
    emit = b_valid && (b_last || (b_rows >= 3'd2));
    b_done_now = !b_last || (j_cur == 2'd0);
  end

  // tap selection: index k = j - d clamped to 0..r
  always_comb begin
    for (int d = -2; d <= 2; d++) begin
      int k;
      k = int'(j_cur) - d;
      if (k < 0) k = 0;
      if (k > int'(rows_clamped)) k = int'(rows_clamped);
      job.tap[d+2] = v[k[2:0]];
    end
    job.run_last   = !b_last || (j_cur == 2'd0);
    job.frame_done = b_last && (j_cur == 2'd0) && b_end;
  end

  assign job_valid = emit;
  assign b_adv = b_valid && (!emit || (job_ready && b_done_now));

  logic [15:0] pix_in;
  assign pix_in = 16'(in_item.sample[PIXEL_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_seen    <= '0;
      b_valid      <= 1'b0;
      b_first      <= 1'b0;
      b_j          <= '0;
      fwd          <= 1'b0;
    end else begin
      if (b_valid && !b_adv) begin
        b_first <= 1'b0;
        if (emit && job_ready) b_j <= j_cur - 2'd1;
        else b_j <= j_cur;
      end
      if (take) begin
        b_valid <= 1'b1;
        b_first <= 1'b1;
        b_pix   <= pix_in;
        b_end   <= in_item.row_end;
        b_last  <= in_item.last_row;
        b_col   <= column_count;
        b_rows  <= rows_seen;
        fwd     <= wr && (b_col == column_count);
        rd_fwd  <= {rd_eff[2:0], b_pix};
        if (in_item.row_end) begin
          column_count <= '0;
          if (in_item.last_row) rows_seen <= '0;
          else if (rows_seen < 3'd4) rows_seen <= rows_seen + 3'd1;
        end else begin
          column_count <= (column_count == AW'(MAX_WIDTH-1)) ? '0
                                                               : column_count + 1'b1;
        end
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end else if (b_valid) begin
        fwd    <= 1'b1;  // hold the effective read while stalled
        rd_fwd <= rd_eff;
      end
    end
  end
endmodule

[hw/rtl/vfir_math.sv]
// Arithmetic pipeline: weighted tap sum, reciprocal multiply, bias, round,
// clamp, then output skid register. Depends on vfir_pkg.
module vfir_math #(
  parameter int TAPS = vfir_pkg::DefTaps
) (
  input  logic               clk,
  input  logic               rst,
  input  vfir_pkg::cfg_t     cfg,
  input  logic               job_valid,
  output logic               job_ready,
  input  vfir_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output vfir_pkg::out_item_t out_item
);
  import vfir_pkg::*;

  // stage 1: products, stage 2: sum, stage 3: scale, stage 4: round/clamp
  logic s1_v, s2_v, s3_v, s4_v;
  logic adv;
  // skid entry parks a stalled result so the pipe stalls from the next cycle
  logic      sk_v;
  out_item_t sk_item;
  out_item_t s4_item;
  assign adv = !sk_v;
  assign job_ready = adv;

  logic signed [4:0][27:0] s1_p;
  logic [1:0] s1_f, s2_f, s3_f;
  logic signed [SumW-1:0] s2_sum;
  logic signed [ProdW-1:0] s3_prod;

  logic signed [ProdW+1:0] t;
  logic signed [ProdW+1:0] q;
  logic [15:0] clamp;

  always_comb begin
    t = (ProdW+2)'(s3_prod) + (ProdW+2)'(cfg.bias) + (ProdW+2)'(32768);
    q = t >>> 16;  // floor
    if (q < 0) clamp = '0;
    else if (q > $signed({1'b0, cfg.max_value})) clamp = cfg.max_value;
    else clamp = q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0;
    end else if (adv) begin
      s1_v <= job_valid; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 5; i++) begin
        if (TAPS == 3 && (i == 0 || i == 4)) s1_p[i] <= '0;
        else s1_p[i] <= 28'($signed(cfg.coef[i]) * $signed({1'b0, job.tap[i]}));
      end
      s1_f     <= {job.run_last, job.frame_done};
      s2_sum   <= SumW'($signed(s1_p[0])) + SumW'($signed(s1_p[1]))
                + SumW'($signed(s1_p[2])) + SumW'($signed(s1_p[3]))
                + SumW'($signed(s1_p[4]));
      s2_f     <= s1_f;
      s3_prod  <= ProdW'(s2_sum) * ProdW'(cfg.recip);
      s3_f     <= s2_f;
      s4_item  <= '{pixel_out: clamp, run_last: s3_f[1], frame_done: s3_f[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_v <= 1'b0;
    end else if (sk_v) begin
      if (out_ready) sk_v <= 1'b0;
    end else if (s4_v && !out_ready) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v && s4_v && !out_ready) sk_item <= s4_item;
  end

  assign out_valid = sk_v || s4_v;
  assign out_item  = sk_v ? sk_item : s4_item;
endmodule

[hw/rtl/vertical_fir_line_buffer_unit.sv]
// Vertical 5-tap FIR over a raster pixel stream, replicated edges.
// Channels: in (valid/ready, in_item_t), out (valid/ready, out_item_t),
// APB-style register port (8 registers at byte address 4*i).
// Each accepted pixel gives 0, 1 or (on the last row) up to 3 results.
// Throughput: one pixel per cycle on normal rows unless the output stalls;
// on the last row one result per cycle, so a pixel there holds the input
// until the single shared arithmetic pipe has taken all of its jobs.
// A pixel's first result passes through line RAM read and tap select,
// products, sum, scale and round/clamp before its transfer.
// Output lags input by two rows; the last row flushes the final rows.
// Reset: synchronous, clears row/column counters and all valid bits;
// line RAMs are not cleared. Registers return to their reset values.
// When the receiver stalls, the result is parked in an output skid
// register and the pipe holds from the next cycle; nothing is lost.
// Depends on vfir_pkg, vfir_front, vfir_math, vfir_ram.
module vertical_fir_line_buffer_unit #(
  parameter int MAX_WIDTH  = vfir_pkg::DefMaxWidth,
  parameter int PIXEL_BITS = vfir_pkg::DefPixelBits,
  parameter int TAPS       = vfir_pkg::DefTaps
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vfir_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output vfir_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vfir_pkg::*;

  cfg_t     cfg;
  reg_idx_t widx;
  logic     job_valid, job_ready;
  job_t     job;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef      <= {11'sd0, 11'sd1, 11'sd1, 11'sd1, 11'sd0};
      cfg.recip     <= 24'sd21845;
      cfg.bias      <= '0;
      cfg.max_value <= 16'd255;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_COEF0: cfg.coef[0]   <= pwdata[CoefW-1:0];
        REG_COEF1: cfg.coef[1]   <= pwdata[CoefW-1:0];
        REG_COEF2: cfg.coef[2]   <= pwdata[CoefW-1:0];
        REG_COEF3: cfg.coef[3]   <= pwdata[CoefW-1:0];
        REG_COEF4: cfg.coef[4]   <= pwdata[CoefW-1:0];
        REG_RECIP: cfg.recip     <= pwdata[RecipW-1:0];
        REG_BIAS:  cfg.bias      <= pwdata;
        REG_MAX:   cfg.max_value <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_COEF0: prdata = 32'({{(32-CoefW){1'b0}}, cfg.coef[0]});
      REG_COEF1: prdata = 32'({{(32-CoefW){1'b0}}, cfg.coef[1]});
      REG_COEF2: prdata = 32'({{(32-CoefW){1'b0}}, cfg.coef[2]});
      REG_COEF3: prdata = 32'({{(32-CoefW){1'b0}}, cfg.coef[3]});
      REG_COEF4: prdata = 32'({{(32-CoefW){1'b0}}, cfg.coef[4]});
      REG_RECIP: prdata = {8'd0, cfg.recip};
      REG_BIAS:  prdata = cfg.bias;
      REG_MAX:   prdata = {16'd0, cfg.max_value};
    endcase
  end

  vfir_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  vfir_math #(.TAPS(TAPS)) u_math (
    .clk(clk), .rst(rst), .cfg(cfg), .job_valid(job_valid),
    .job_ready(job_ready), .job(job), .out_valid(out_valid),
    .out_ready(out_ready), .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_done |-> out_item.run_last)
    else $error("frame_done without run_last");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pixel_out <= cfg.max_value)
    else $error("result above max_value");
`endif
endmodule
